// ----- rtl/nsr_pkg.sv -----
// Shared types and constants for the Newton square root block.
package nsr_pkg;

	localparam int ITER_W = 6;
	localparam logic [ITER_W-1:0] ITER_RESET = 6'd20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIFF,
		ST_DINIT,
		ST_DIV,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_init;
		logic mul_step;
		logic diff;
		logic dinit;
		logic div_step;
		logic update;
		logic set_dz;
	} cmd_t;

	typedef struct packed {
		logic y_zero;
		logic big;
	} stat_t;

endpackage

// ----- rtl/newton_square_root.sv -----
// Top level: Newton-Raphson square root, unsigned fixed point.
// Usage:
//  - Input beat: square_value and start_guess are taken at a rising edge with
//    start high and busy low. busy stays high until the result strobe is done.
//  - Result beat: root and div_zero are valid for exactly one cycle while done
//    is high. The receiver cannot stall; it must take the beat in that cycle.
//  - Configuration: iteration_count is written when cfg_valid and cfg_ready are
//    both high; cfg_ready is high only while the block is idle. Reset value 20.
//  - Each Newton step runs a shift-add squarer and a restoring divider (skipped on
//    overflow, where the update saturates), plus four control states: check,
//    difference, divider setup and update.
//  - The next input beat is taken only after done, once the controller is idle.
//  - A zero iterate before a step stops the item: root 0, div_zero 1.
//  - Reset clears the controller to idle and restores the iteration count.
module newton_square_root #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [DATA_WIDTH-1:0]      square_value,
	input  logic [DATA_WIDTH-1:0]      start_guess,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      root,
	output logic                       div_zero,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [nsr_pkg::ITER_W-1:0] iteration_count
);

	nsr_pkg::cmd_t  cmd;
	nsr_pkg::stat_t stat;

	nsr_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.done           (done),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.iteration_count(iteration_count),
		.stat           (stat),
		.cmd            (cmd)
	);

	nsr_datapath #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.square_value(square_value),
		.start_guess (start_guess),
		.root        (root),
		.div_zero    (div_zero)
	);

endmodule

// ----- rtl/nsr_datapath.sv -----
// Datapath: operand registers, shift-add squarer, restoring divider, saturating update.
module nsr_datapath #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nsr_pkg::cmd_t         cmd,
	output nsr_pkg::stat_t        stat,
	input  logic [DATA_WIDTH-1:0] square_value,
	input  logic [DATA_WIDTH-1:0] start_guess,
	output logic [DATA_WIDTH-1:0] root,
	output logic                  div_zero
);

	localparam int W  = DATA_WIDTH;
	localparam int DW = (2 * W > W + FRAC_BITS) ? 2 * W : W + FRAC_BITS;
	localparam int RW = DW - W;
	localparam int CW = (RW > W + 1) ? RW : W + 1;

	logic [W-1:0]  s_q, y_q, ph_q, pl_q, ql_q;
	logic [DW-1:0] d_q;
	logic [W:0]    r_q;
	logic          up_q, big_q, dz_q;

	logic [W:0]    mul_sum;
	logic [DW-1:0] sv, sq;
	logic [DW:0]   dd;
	logic [DW-1:0] dmag;
	logic [W:0]    dv;
	logic [CW-1:0] hi_ext;
	logic          big;
	logic [W+1:0]  rs;
	logic          ge;
	logic [W+1:0]  rsub;
	logic [W:0]    ysum;
	logic [W-1:0]  y_next;

	always_comb begin
		mul_sum = {1'b0, ph_q} + (pl_q[0] ? {1'b0, y_q} : '0);
		sv      = DW'(s_q) << FRAC_BITS;
		sq      = DW'({ph_q, pl_q});
		dd      = {1'b0, sv} - {1'b0, sq};
		dmag    = dd[DW] ? (~dd[DW-1:0] + DW'(1)) : dd[DW-1:0];
		dv      = {y_q, 1'b0};
		hi_ext  = CW'(d_q[DW-1:W]);
		big     = hi_ext >= CW'(dv);
		rs      = {r_q, ql_q[W-1]};
		ge      = rs >= {1'b0, dv};
		rsub    = rs - {1'b0, dv};
		ysum    = {1'b0, y_q} + {1'b0, ql_q};
		if (up_q) begin
			y_next = (big_q || ysum[W]) ? '1 : ysum[W-1:0];
		end else begin
			y_next = (big_q || ql_q > y_q) ? '0 : y_q - ql_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q  <= '0;
			y_q  <= '0;
			dz_q <= 1'b0;
		end else if (cmd.load) begin
			s_q  <= square_value;
			y_q  <= start_guess;
			dz_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				y_q <= y_next;
			end
			if (cmd.set_dz) begin
				dz_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			ph_q <= '0;
			pl_q <= y_q;
		end else if (cmd.mul_step) begin
			ph_q <= mul_sum[W:1];
			pl_q <= {mul_sum[0], pl_q[W-1:1]};
		end
		if (cmd.diff) begin
			d_q  <= dmag;
			up_q <= ~dd[DW];
		end
		if (cmd.dinit) begin
			big_q <= big;
			r_q   <= hi_ext[W:0];
			ql_q  <= d_q[W-1:0];
		end else if (cmd.div_step) begin
			r_q  <= ge ? rsub[W:0] : rs[W:0];
			ql_q <= {ql_q[W-2:0], ge};
		end
	end

	assign stat.y_zero = (y_q == '0);
	assign stat.big    = big;
	assign root        = y_q;
	assign div_zero    = dz_q;

endmodule

// ----- rtl/nsr_ctrl.sv -----
// Controller: step sequencing, bit counter, iteration count register.
module nsr_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	output logic                       done,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [nsr_pkg::ITER_W-1:0] iteration_count,
	input  nsr_pkg::stat_t             stat,
	output nsr_pkg::cmd_t              cmd
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	nsr_pkg::state_t             state_q, state_d;
	logic [nsr_pkg::ITER_W-1:0]  iter_q, step_cnt_q;
	logic [CNT_W-1:0]            bit_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q     <= nsr_pkg::ITER_RESET;
			step_cnt_q <= '0;
			bit_cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				iter_q <= iteration_count;
			end
			if (cmd.load) begin
				step_cnt_q <= '0;
			end else if (cmd.update) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end
			if (cmd.mul_init || cmd.dinit) begin
				bit_cnt_q <= CNT_W'(DATA_WIDTH - 1);
			end else if (cmd.mul_step || cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			nsr_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cfg_ready = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = nsr_pkg::ST_CHECK;
				end
			end
			nsr_pkg::ST_CHECK: begin
				if (step_cnt_q == iter_q) begin
					state_d = nsr_pkg::ST_DONE;
				end else if (stat.y_zero) begin
					cmd.set_dz = 1'b1;
					state_d    = nsr_pkg::ST_DONE;
				end else begin
					cmd.mul_init = 1'b1;
					state_d      = nsr_pkg::ST_MUL;
				end
			end
			nsr_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = nsr_pkg::ST_DIFF;
				end
			end
			nsr_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = nsr_pkg::ST_DINIT;
			end
			nsr_pkg::ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = stat.big ? nsr_pkg::ST_UPD : nsr_pkg::ST_DIV;
			end
			nsr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = nsr_pkg::ST_UPD;
				end
			end
			nsr_pkg::ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = nsr_pkg::ST_CHECK;
			end
			nsr_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = nsr_pkg::ST_IDLE;
			end
			default: begin
				state_d = nsr_pkg::ST_IDLE;
			end
		endcase
	end

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_start_enters_check: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == nsr_pkg::ST_CHECK))
		else $error("accepted beat did not start a step check");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nsr_pkg::ST_DIV && bit_cnt_q == '0) |=> (state_q == nsr_pkg::ST_UPD))
		else $error("divide did not finish on count");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (step_cnt_q <= iter_q))
		else $error("more steps than configured");

endmodule
